/* hw/rtl/signed_alu_add_sub_mul_div_mod_macros.svh */
// assertion macros used by the checker file
`ifndef SIGNED_ALU_ADD_SUB_MUL_DIV_MOD_MACROS_SVH
`define SIGNED_ALU_ADD_SUB_MUL_DIV_MOD_MACROS_SVH

// plain clocked assertion, off while reset is held
`define SAU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sau check failed");

// antecedent now, consequent a fixed number of cycles later
`define SAU_ASSERT_LAT(lbl, clk, rstn, ante, lat, cons) \
    `SAU_ASSERT(lbl, clk, rstn, (ante) |-> ##(lat) (cons))

`endif

/* hw/rtl/sau_pkg.sv */
// shared types, codes and sizes for the signed alu
`default_nettype none

package sau_pkg;

    // operand width and derived sizes
    localparam int W       = 16;
    localparam int RW      = 32;
    localparam int LATENCY = W + 2;

    // operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;

    // how the end of the chain forms the result
    localparam logic [1:0] K_SMP = 2'd0;
    localparam logic [1:0] K_QUO = 2'd1;
    localparam logic [1:0] K_REM = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] operand_a;
        logic signed [15:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               error_code;
    } t_rsp;

    // payload carried from cell to cell
    typedef struct packed {
        logic [1:0]    kind;
        logic          neg;
        logic          err;
        logic [RW-1:0] simple;
        logic [W-1:0]  prem;
        logic [W-1:0]  quo;
        logic [W-1:0]  dvs;
    } t_lane;

endpackage

`default_nettype wire

/* hw/rtl/sau_front.sv */
// entry stage: decode, add, subtract, multiply and divider setup
`default_nettype none

module sau_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire sau_pkg::t_req i_req,
    output logic               o_vld,
    output sau_pkg::t_lane     o_lane
);

    logic                          r_vld;
    sau_pkg::t_lane                r_lane;
    sau_pkg::t_lane                n_lane;
    logic signed [sau_pkg::W-1:0]  a;
    logic signed [sau_pkg::W-1:0]  b;
    logic [sau_pkg::RW-1:0]        a_ext;
    logic [sau_pkg::RW-1:0]        b_ext;
    logic signed [sau_pkg::RW-1:0] prod;
    logic [sau_pkg::W-1:0]         mag_a;
    logic [sau_pkg::W-1:0]         mag_b;
    logic                          dz;

    // operands as signed values and their magnitudes
    assign a     = i_req.operand_a[sau_pkg::W-1:0];
    assign b     = i_req.operand_b[sau_pkg::W-1:0];
    assign a_ext = {{(sau_pkg::RW-sau_pkg::W){a[sau_pkg::W-1]}}, a};
    assign b_ext = {{(sau_pkg::RW-sau_pkg::W){b[sau_pkg::W-1]}}, b};
    assign prod  = a * b;
    assign mag_a = a[sau_pkg::W-1] ? sau_pkg::W'(-a) : a;
    assign mag_b = b[sau_pkg::W-1] ? sau_pkg::W'(-b) : b;
    assign dz    = (b == '0);

    // choose what the chain carries for this item
    always_comb begin
        n_lane        = '0;
        n_lane.prem   = '0;
        n_lane.quo    = mag_a;
        n_lane.dvs    = mag_b;
        n_lane.kind   = sau_pkg::K_SMP;
        unique case (i_req.req_type)
            sau_pkg::OP_ADD: begin
                n_lane.simple = a_ext + b_ext;
            end
            sau_pkg::OP_SUB: begin
                n_lane.simple = a_ext - b_ext;
            end
            sau_pkg::OP_MUL: begin
                n_lane.simple = prod;
            end
            sau_pkg::OP_DIV: begin
                n_lane.err  = dz;
                n_lane.kind = dz ? sau_pkg::K_SMP : sau_pkg::K_QUO;
                n_lane.neg  = a[sau_pkg::W-1] ^ b[sau_pkg::W-1];
            end
            sau_pkg::OP_REM: begin
                n_lane.err  = dz;
                n_lane.kind = dz ? sau_pkg::K_SMP : sau_pkg::K_REM;
                n_lane.neg  = a[sau_pkg::W-1];
            end
            default: begin
                n_lane.simple = '0;
            end
        endcase
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_take;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

`default_nettype wire

/* hw/rtl/sau_cell.sv */
// one restoring division step, registered, handing its item to the next cell
`default_nettype none

module sau_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire sau_pkg::t_lane i_lane,
    output logic                o_vld,
    output sau_pkg::t_lane      o_lane
);

    logic               r_vld;
    sau_pkg::t_lane     r_lane;
    sau_pkg::t_lane     n_lane;
    logic [sau_pkg::W:0] trial;

    // shift in the next dividend bit and try the subtraction
    assign trial = {i_lane.prem, i_lane.quo[sau_pkg::W-1]} - {1'b0, i_lane.dvs};

    always_comb begin
        n_lane = i_lane;
        if (!trial[sau_pkg::W]) begin
            n_lane.prem = trial[sau_pkg::W-1:0];
            n_lane.quo  = {i_lane.quo[sau_pkg::W-2:0], 1'b1};
        end else begin
            n_lane.prem = {i_lane.prem[sau_pkg::W-2:0], i_lane.quo[sau_pkg::W-1]};
            n_lane.quo  = {i_lane.quo[sau_pkg::W-2:0], 1'b0};
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

`default_nettype wire

/* hw/rtl/signed_alu_add_sub_mul_div_mod.sv */
// top level of the signed alu: entry stage, divider cell row, result register
//
// Usage
//   Input channel: an item (opcode, two 16-bit signed operands on i_req) is
//   taken at a rising edge where start is high and busy is low. busy is low
//   whenever reset is released, so a new item may be issued every cycle.
//   Result channel: o_done is high for exactly one cycle per result, with o_rsp valid;
//   the receiver must take it then and cannot hold results off.
//   Path: every operation passes through one entry stage (add, subtract and
//   the 16x16 multiplier), sixteen division cells of one quotient bit each,
//   and the output register that fixes signs.
//   Throughput: one item per cycle; items leave in issue order.
//   Divide or remainder by zero gives result zero with error_code set; the
//   unused opcodes give zero with no error.
//   Reset: synchronous, active low; it drops every item in flight and holds
//   busy high while asserted.
`default_nettype none

module signed_alu_add_sub_mul_div_mod (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire sau_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output sau_pkg::t_rsp      o_rsp
);

    logic                    s_vld  [0:sau_pkg::W];
    sau_pkg::t_lane          s_lane [0:sau_pkg::W];
    logic                    take;
    logic                    r_done;
    sau_pkg::t_rsp           r_rsp;
    sau_pkg::t_rsp           n_rsp;
    sau_pkg::t_lane          last;
    logic [sau_pkg::RW-1:0]  mag;

    assign busy = !i_rst_n;
    assign take = start && !busy;

    // entry stage
    sau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_req),
        .o_vld   (s_vld[0]),
        .o_lane  (s_lane[0])
    );

    // row of division cells, one quotient bit each
    for (genvar g = 0; g < sau_pkg::W; g++) begin : g_cell
        sau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (s_vld[g]),
            .i_lane  (s_lane[g]),
            .o_vld   (s_vld[g+1]),
            .o_lane  (s_lane[g+1])
        );
    end

    // final sign fix and result selection
    assign last = s_lane[sau_pkg::W];

    always_comb begin
        mag = '0;
        n_rsp.error_code = last.err;
        unique case (last.kind)
            sau_pkg::K_QUO: mag = {{(sau_pkg::RW-sau_pkg::W){1'b0}}, last.quo};
            sau_pkg::K_REM: mag = {{(sau_pkg::RW-sau_pkg::W){1'b0}}, last.prem};
            default:        mag = '0;
        endcase
        if (last.kind == sau_pkg::K_SMP) begin
            n_rsp.result_value = last.simple;
        end else begin
            n_rsp.result_value = last.neg ? -mag : mag;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s_vld[sau_pkg::W];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

/* hw/rtl/sau_chk.sv */
// port-level checker for the signed alu, bound to the top level
`default_nettype none
`include "signed_alu_add_sub_mul_div_mod_macros.svh"

module sau_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_done,
    input wire sau_pkg::t_req i_req,
    input wire sau_pkg::t_rsp o_rsp
);

    logic                   take;
    logic [sau_pkg::RW-1:0] add_ref;

    assign take    = start && !busy;
    assign add_ref = {{(sau_pkg::RW-16){i_req.operand_a[15]}}, i_req.operand_a}
                   + {{(sau_pkg::RW-16){i_req.operand_b[15]}}, i_req.operand_b};

    // every item comes out after the fixed latency
    `SAU_ASSERT_LAT(a_lat, i_clk, i_rst_n, take, sau_pkg::LATENCY, o_done)

    // no result without an item issued one latency earlier
    `SAU_ASSERT(a_no_extra, i_clk, i_rst_n, o_done |-> $past(take, sau_pkg::LATENCY))

    // divide by zero is flagged at the output
    `SAU_ASSERT_LAT(a_dz, i_clk, i_rst_n, take && i_req.req_type == sau_pkg::OP_DIV && i_req.operand_b == '0, sau_pkg::LATENCY, o_rsp.error_code)

    // sums come out unchanged through the cell row
    `SAU_ASSERT_LAT(a_add, i_clk, i_rst_n, take && i_req.req_type == sau_pkg::OP_ADD, sau_pkg::LATENCY, o_rsp.result_value == $past(add_ref, sau_pkg::LATENCY))

endmodule

bind signed_alu_add_sub_mul_div_mod sau_chk u_sau_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);

`default_nettype wire
